// File: rtl/bae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bae_pkg;

  localparam int unsigned DEF_MAX_DEVICES = 8;
  localparam int unsigned NUM_BUTTONS     = 9;
  localparam int unsigned NUM_AXES        = 2;

  localparam int unsigned DEV_W  = 3;
  localparam int unsigned KEY_W  = 4;
  localparam int unsigned AXIS_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;

  // button counter holds 0..NUM_BUTTONS, button index 0..NUM_BUTTONS-1
  localparam int unsigned BTN_CW = $clog2(NUM_BUTTONS + 1);
  localparam int unsigned BTN_IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  localparam logic [CFG_W-1:0] DEF_INIT_DELAY = 16'd200;
  localparam logic [CFG_W-1:0] DEF_REPEAT_IVL = 16'd100;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_REPEAT  = 2'd2,
    KIND_ANALOG  = 2'd3
  } ev_kind_e;

  typedef enum logic {
    REG_INIT_DELAY = 1'b0,
    REG_REPEAT_IVL = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              cmd;
    logic [DEV_W-1:0]  dev;
    logic [8:0]        bits;
    logic [3:0]        bcount;
    logic [1:0]        acount;
    logic [AXIS_W-1:0] ax;
    logic [AXIS_W-1:0] ay;
    logic [TIME_W-1:0] now;
  } bae_item_t;

  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    ev_kind_e          kind;
    logic [KEY_W-1:0]  key;
    logic [AXIS_W-1:0] value;
  } bae_evt_t;

  typedef struct packed {
    logic     push;
    logic     flush;
    bae_evt_t evt;
  } bae_oq_req_t;

endpackage

`default_nettype wire

// File: rtl/bae_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bae_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/bae_out.sv
`timescale 1ns / 1ps
`default_nettype none

module bae_out
  import bae_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire bae_oq_req_t req_i,
  output logic             can_push_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output bae_evt_t         m_evt_o,
  output logic             m_last_o
);

  // one event is held back until it is known whether another follows
  bae_evt_t pend_q;
  logic     pend_vld_q;
  bae_evt_t out_q;
  logic     out_last_q;
  logic     out_vld_q;
  logic     out_free;

  assign out_free   = !out_vld_q || m_ready_i;
  assign can_push_o = !pend_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      out_q      <= '0;
      out_last_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (req_i.push) begin
        if (pend_vld_q) begin
          out_q      <= pend_q;
          out_last_q <= 1'b0;
          out_vld_q  <= 1'b1;
        end else if (m_ready_i) begin
          out_vld_q <= 1'b0;
        end
        pend_q     <= req_i.evt;
        pend_vld_q <= 1'b1;
      end else if (req_i.flush && pend_vld_q && out_free) begin
        out_q      <= pend_q;
        out_last_q <= 1'b1;
        out_vld_q  <= 1'b1;
        pend_vld_q <= 1'b0;
      end else if (m_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = out_vld_q;
  assign m_evt_o   = out_q;
  assign m_last_o  = out_last_q;

endmodule

`default_nettype wire

// File: rtl/bae_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bae_core
  import bae_pkg::*;
#(
  parameter int unsigned MAX_DEVICES = DEF_MAX_DEVICES
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire bae_item_t        item_i,
  input  wire logic [CFG_W-1:0] init_dly_i,
  input  wire logic [CFG_W-1:0] rpt_ivl_i,
  input  wire logic             can_push_i,
  output bae_oq_req_t           req_o
);

  localparam int unsigned DEV_AW   = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int unsigned DL_DEPTH = MAX_DEVICES * NUM_BUTTONS;
  localparam int unsigned DL_AW    = (DL_DEPTH > 1) ? $clog2(DL_DEPTH) : 1;
  localparam int unsigned ST_W     = NUM_BUTTONS + NUM_AXES * AXIS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_BTN,
    S_AXIS,
    S_FLUSH
  } state_e;

  state_e                           state_q, state_d;
  logic [DEV_W-1:0]                 dev_q, dev_d;
  logic [8:0]                       bits_q, bits_d;
  logic [BTN_CW-1:0]                nbtn_q, nbtn_d;
  logic [1:0]                       nax_q, nax_d;
  logic [NUM_AXES-1:0][AXIS_W-1:0]  axis_q, axis_d;
  logic [TIME_W-1:0]                now_q, now_d;
  logic [DL_AW-1:0]                 base_q, base_d;
  logic [BTN_CW-1:0]                i_q, i_d;
  logic [1:0]                       j_q, j_d;
  logic [NUM_BUTTONS-1:0]           held_q, held_d;
  logic [NUM_AXES-1:0][AXIS_W-1:0]  last_q, last_d;
  logic [MAX_DEVICES-1:0]           started_q, started_d;

  logic              dev_ok;
  logic [DEV_AW-1:0] dev_a_in;
  logic [DEV_AW-1:0] dev_a;
  logic [ST_W-1:0]   st_rdata;
  logic              st_we;
  logic [TIME_W-1:0] dl_rdata;
  logic [TIME_W-1:0] dl_wdata;
  logic [TIME_W-1:0] dl_diff;
  logic              dl_we;
  logic              passed;
  logic              btn_on;
  logic              btn_was;
  logic              btn_last;
  logic              ax_last;
  logic [BTN_IW-1:0] bi;
  logic              aj;
  logic [AXIS_W-1:0] ax_cur;
  logic              ev;
  ev_kind_e          ev_kind;

  assign dev_ok   = 32'(item_i.dev) < MAX_DEVICES;
  assign dev_a_in = DEV_AW'(32'(item_i.dev));
  assign dev_a    = DEV_AW'(32'(dev_q));

  assign bi       = i_q[BTN_IW-1:0];
  assign aj       = j_q[0];
  assign btn_on   = bits_q[bi];
  assign btn_was  = held_q[bi];
  assign btn_last = (32'(i_q) + 32'd1) == 32'(nbtn_q);
  assign ax_last  = (32'(j_q) + 32'd1) == 32'(nax_q);
  assign ax_cur   = axis_q[aj];

  // wrap-aware: passed when now - deadline lies in 1 .. 2^31-1
  assign dl_diff  = now_q - dl_rdata;
  assign passed   = (dl_diff != '0) && !dl_diff[TIME_W-1];

  always_comb begin
    state_d   = state_q;
    dev_d     = dev_q;
    bits_d    = bits_q;
    nbtn_d    = nbtn_q;
    nax_d     = nax_q;
    axis_d    = axis_q;
    now_d     = now_q;
    base_d    = base_q;
    i_d       = i_q;
    j_d       = j_q;
    held_d    = held_q;
    last_d    = last_q;
    started_d = started_q;
    ev        = 1'b0;
    ev_kind   = KIND_PRESS;
    dl_we     = 1'b0;
    st_we     = 1'b0;
    req_o     = '0;
    dl_wdata  = now_q + TIME_W'(init_dly_i);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && dev_ok) begin
          if (item_i.cmd) begin
            started_d[dev_a_in] = 1'b0;
          end else begin
            dev_d   = item_i.dev;
            bits_d  = item_i.bits;
            nbtn_d  = (32'(item_i.bcount) > NUM_BUTTONS) ? BTN_CW'(NUM_BUTTONS)
                                                         : BTN_CW'(item_i.bcount);
            nax_d   = (32'(item_i.acount) > NUM_AXES) ? 2'(NUM_AXES) : item_i.acount;
            for (int a = 0; a < NUM_AXES; a++) begin
              axis_d[a] = (a == 0) ? item_i.ax : item_i.ay;
            end
            now_d   = item_i.now;
            base_d  = DL_AW'(32'(item_i.dev) * NUM_BUTTONS);
            i_d     = '0;
            j_d     = '0;
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        // a device never started reads as all released, axes at zero
        held_d = started_q[dev_a] ? st_rdata[NUM_BUTTONS-1:0] : '0;
        last_d = started_q[dev_a] ? st_rdata[ST_W-1:NUM_BUTTONS] : '0;
        started_d[dev_a] = 1'b1;
        if (nbtn_q != '0) begin
          state_d = S_BTN;
        end else if (nax_q != '0) begin
          state_d = S_AXIS;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_BTN: begin
        if (btn_on != btn_was) begin
          ev      = 1'b1;
          ev_kind = btn_on ? KIND_PRESS : KIND_RELEASE;
        end else if (btn_on && passed) begin
          ev       = 1'b1;
          ev_kind  = KIND_REPEAT;
          dl_wdata = now_q + TIME_W'(rpt_ivl_i);
        end
        if (!ev || can_push_i) begin
          req_o.push      = ev;
          req_o.evt.dev   = dev_q;
          req_o.evt.kind  = ev_kind;
          req_o.evt.key   = KEY_W'(i_q);
          req_o.evt.value = '0;
          dl_we           = ev && btn_on;
          held_d[bi]      = btn_on;
          if (btn_last) begin
            state_d = (nax_q != '0) ? S_AXIS : S_FLUSH;
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end
      S_AXIS: begin
        ev = ax_cur != last_q[aj];
        if (!ev || can_push_i) begin
          req_o.push      = ev;
          req_o.evt.dev   = dev_q;
          req_o.evt.kind  = KIND_ANALOG;
          req_o.evt.key   = KEY_W'(j_q);
          req_o.evt.value = ax_cur;
          last_d[aj]      = ax_cur;
          if (ax_last) begin
            state_d = S_FLUSH;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        st_we       = 1'b1;
        req_o.flush = 1'b1;
        if (can_push_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      dev_q     <= '0;
      bits_q    <= '0;
      nbtn_q    <= '0;
      nax_q     <= '0;
      axis_q    <= '0;
      now_q     <= '0;
      base_q    <= '0;
      i_q       <= '0;
      j_q       <= '0;
      held_q    <= '0;
      last_q    <= '0;
      started_q <= '0;
    end else begin
      state_q   <= state_d;
      dev_q     <= dev_d;
      bits_q    <= bits_d;
      nbtn_q    <= nbtn_d;
      nax_q     <= nax_d;
      axis_q    <= axis_d;
      now_q     <= now_d;
      base_q    <= base_d;
      i_q       <= i_d;
      j_q       <= j_d;
      held_q    <= held_d;
      last_q    <= last_d;
      started_q <= started_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

  // per-device held buttons and last axis values
  bae_ram #(
    .WIDTH (ST_W),
    .DEPTH (MAX_DEVICES)
  ) u_st_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (dev_a),
    .wdata_i ({last_q, held_q}),
    .raddr_i (dev_a_in),
    .rdata_o (st_rdata)
  );

  // repeat deadlines, read one button ahead of the walk
  bae_ram #(
    .WIDTH (TIME_W),
    .DEPTH (DL_DEPTH)
  ) u_dl_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (base_q + DL_AW'(i_q)),
    .wdata_i (dl_wdata),
    .raddr_i (base_q + DL_AW'(i_d)),
    .rdata_o (dl_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/button_autorepeat_event_generator_unit.sv
// Button autorepeat event generator.
// Slave stream: one beat per controller frame or clear command (tuser = 1).
// A frame is compared against the device's held buttons, repeat deadlines
// and last axis values; each change, expired deadline or moved axis yields
// one beat on the master stream, buttons 0 upward, then axis x, then y.
// tlast marks the final event of a frame; clears and frames with no
// change produce nothing.
// A frame occupies the block from acceptance through a load state, the walk
// through the deadline memory, one button per cycle while the output is not
// stalled, then the axes and a flush state. Clear commands leave the block
// ready. The first event waits in the held-back slot before the output register.
// The master side has an output register plus one held-back event; when
// the receiver stalls, the button walk waits and s_axis_tready stays low
// until the frame's last event is in the output register.
// Reset: all devices read as unstarted (buttons released, axes zero),
// delays at 200 ms and 100 ms. No clearing pass is needed.
// Config writes (cfg_addr_i 0: initial delay, 1: repeat interval) apply
// at once and are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none

module button_autorepeat_event_generator_unit
  import bae_pkg::*;
#(
  parameter int unsigned MAX_DEVICES = DEF_MAX_DEVICES
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // device_index, button_bits, button_count, axis_count, axis_x, axis_y, now_ms
  input  wire logic [87:0]      s_axis_tdata,
  // command
  input  wire logic             s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // event_device, key_index, analog_value
  output logic      [23:0]      m_axis_tdata,
  // event_kind
  output logic      [1:0]       m_axis_tuser,
  output logic                  m_axis_tlast,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_addr_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i
);

  logic [CFG_W-1:0] init_dly_q;
  logic [CFG_W-1:0] rpt_ivl_q;
  bae_item_t        item;
  bae_oq_req_t      oq_req;
  logic             can_push;
  bae_evt_t         m_evt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_dly_q <= DEF_INIT_DELAY;
      rpt_ivl_q  <= DEF_REPEAT_IVL;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_INIT_DELAY: init_dly_q <= cfg_wdata_i;
        REG_REPEAT_IVL: rpt_ivl_q  <= cfg_wdata_i;
      endcase
    end
  end

  always_comb begin
    item.cmd    = s_axis_tuser;
    item.dev    = s_axis_tdata[2:0];
    item.bits   = s_axis_tdata[11:3];
    item.bcount = s_axis_tdata[15:12];
    item.acount = s_axis_tdata[17:16];
    item.ax     = s_axis_tdata[33:18];
    item.ay     = s_axis_tdata[49:34];
    item.now    = s_axis_tdata[81:50];
  end

  bae_core #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .item_i     (item),
    .init_dly_i (init_dly_q),
    .rpt_ivl_i  (rpt_ivl_q),
    .can_push_i (can_push),
    .req_o      (oq_req)
  );

  bae_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (oq_req),
    .can_push_o (can_push),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_evt_o    (m_evt),
    .m_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, m_evt.value, m_evt.key, m_evt.dev};
  assign m_axis_tuser = m_evt.kind;

endmodule

`default_nettype wire

// File: rtl/bae_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module bae_chk
  import bae_pkg::*;
#(
  parameter int unsigned MAX_DEVICES = DEF_MAX_DEVICES
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic [87:0]      s_axis_tdata,
  input wire logic             s_axis_tuser,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [23:0]      m_axis_tdata,
  input wire logic [1:0]       m_axis_tuser,
  input wire logic             m_axis_tlast
);

  // a clear beat finishes in its own cycle
  a_clear_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> s_axis_tready)
    else $error("block busy after clear beat");

  // a frame for a tracked device leaves the block busy after it is accepted
  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser &&
    (32'(s_axis_tdata[2:0]) < MAX_DEVICES) |=> !s_axis_tready)
    else $error("frame accepted without busy phase");

  // while idle, anything left in the output register closes a frame
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("idle with an unterminated event run");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled output beat changed");

endmodule

bind button_autorepeat_event_generator_unit bae_chk #(
  .MAX_DEVICES (MAX_DEVICES)
) u_bae_chk (.*);

`default_nettype wire
